// ----- rtl/indexed_array_list_unit_macros.svh -----
// Assertion helpers for the indexed array list unit.
`ifndef INDEXED_ARRAY_LIST_UNIT_MACROS_SVH
`define INDEXED_ARRAY_LIST_UNIT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define IAU_ASSERT_SAME(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define IAU_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ----- rtl/iau_pkg.sv -----
`default_nettype none

package iau_pkg;

  localparam int unsigned CapacityDefault = 64;
  localparam int unsigned WordW = 32;

  typedef logic signed [WordW-1:0] word_t;

  // Request kinds as they arrive on the request channel.
  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_READ   = 3'd3,
    REQ_WRITE  = 3'd4
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Per-cycle update applied to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_WRITE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    word;
  } cell_cmd_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_t;

endpackage

`default_nettype wire

// ----- rtl/iau_cell.sv -----
`default_nettype none

module iau_cell #(
  parameter int unsigned CAPACITY = iau_pkg::CapacityDefault,
  parameter int unsigned INDEX = 0,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned PosW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk,
  input  wire iau_pkg::cell_cmd_t cmd,
  input  wire logic [PosW-1:0]   pos,
  input  wire logic [PosW-1:0]   count,
  input  wire logic              scan_en,
  input  wire iau_pkg::word_t    prev_entry,
  input  wire iau_pkg::word_t    next_entry,
  input  wire logic              hit_in,
  input  wire logic [IdxW-1:0]   idx_in,
  input  wire iau_pkg::word_t    data_in,
  output iau_pkg::word_t         entry,
  output logic                   hit_out,
  output logic [IdxW-1:0]        idx_out,
  output iau_pkg::word_t         data_out
);

  localparam logic [PosW-1:0] MyPos = PosW'(INDEX);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(INDEX);

  logic my_hit;
  logic my_sel;

  // Compare this entry against the searched word and the requested slot.
  assign my_hit = (MyPos < count) && (entry == cmd.word);
  assign my_sel = (MyPos == pos);

  // Shift from a neighbor or take the new word.
  always_ff @(posedge clk) begin
    case (cmd.op)
      iau_pkg::OP_INSERT: begin
        if (MyPos > pos) begin
          entry <= prev_entry;
        end else if (MyPos == pos) begin
          entry <= cmd.word;
        end
      end
      iau_pkg::OP_REMOVE: begin
        if (MyPos >= pos) begin
          entry <= next_entry;
        end
      end
      iau_pkg::OP_WRITE: begin
        if (my_sel) begin
          entry <= cmd.word;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance the probe one cell; the first match upstream wins.
  always_ff @(posedge clk) begin
    if (scan_en) begin
      hit_out  <= hit_in | my_hit;
      idx_out  <= hit_in ? idx_in : MyIdx;
      data_out <= my_sel ? entry : data_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/indexed_array_list_unit.sv -----
// Indexed array list: ordered list of up to CAPACITY signed 32-bit words.
// Request channel (req_valid/req_stall) carries req_type, position, word_in;
// response channel (rsp_valid/rsp_stall) returns status, found_position,
// word_out and entry_count, exactly one word per request.
// Insert, remove and write update the cell chain in the accept cycle; for
// these and any rejected request the response is presented on the next cycle.
// Find and in-range read send a probe down the chain of cells, one cell per
// cycle; the response is loaded once the probe has passed the last cell.
// One request is in flight at a time. A new request is taken while the
// previous response is still offered, provided that response is taken in
// the same cycle; insert/remove/write thus sustain one per cycle unless stalled.
// A stalled response holds its payload; a finished probe result waits in
// the last cell until the response register frees up.
// Reset empties the list (count zero) and drops any pending response; the
// stored words are not cleared and are never observed before being written.
`default_nettype none
`include "indexed_array_list_unit_macros.svh"

module indexed_array_list_unit #(
  parameter int unsigned CAPACITY = iau_pkg::CapacityDefault,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned PosW = $clog2(CAPACITY + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic [2:0]         req_type,
  input  wire logic [PosW-1:0]    position,
  input  wire logic signed [31:0] word_in,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic [1:0]              status,
  output logic [IdxW-1:0]         found_position,
  output logic signed [31:0]      word_out,
  output logic [PosW-1:0]         entry_count
);

  localparam logic [PosW-1:0] Full = PosW'(CAPACITY);

  iau_pkg::fsm_t      state, state_next;
  logic [PosW-1:0]    count, count_next;
  logic [PosW-1:0]    scan_cnt;
  iau_pkg::req_kind_t rq_kind;
  logic [PosW-1:0]    rq_pos;
  iau_pkg::word_t     rq_word;

  logic               rsp_free;
  logic               accept;
  logic               launch;
  logic               load_rsp;
  logic               scan_en;
  logic               ins_ok;
  iau_pkg::status_t   rsp_status_next;
  logic [IdxW-1:0]    rsp_found_next;
  iau_pkg::word_t     rsp_word_next;
  iau_pkg::cell_cmd_t cmd;
  logic [PosW-1:0]    cell_pos;

  iau_pkg::word_t     entry [CAPACITY];
  logic               p_hit [CAPACITY];
  logic [IdxW-1:0]    p_idx [CAPACITY];
  iau_pkg::word_t     p_data [CAPACITY];

  // Handshake.
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == iau_pkg::FSM_IDLE) && rsp_free);
  assign accept    = req_valid && !req_stall;
  assign scan_en   = (state == iau_pkg::FSM_SCAN) && (scan_cnt != Full);
  assign cell_pos  = (state == iau_pkg::FSM_IDLE) ? position : rq_pos;
  assign entry_count = count;

  // Decode the request and finish the probe.
  always_comb begin
    state_next      = state;
    count_next      = count;
    launch          = 1'b0;
    load_rsp        = 1'b0;
    ins_ok          = 1'b0;
    rsp_status_next = iau_pkg::ST_OK;
    rsp_found_next  = '0;
    rsp_word_next   = '0;
    cmd.op          = iau_pkg::OP_HOLD;
    cmd.word        = (state == iau_pkg::FSM_IDLE) ? word_in : rq_word;
    case (state)
      iau_pkg::FSM_IDLE: begin
        if (accept) begin
          case (req_type)
            iau_pkg::REQ_INSERT: begin
              load_rsp = 1'b1;
              if (position > count) begin
                rsp_status_next = iau_pkg::ST_RANGE;
              end else if (count == Full) begin
                rsp_status_next = iau_pkg::ST_FULL;
              end else begin
                ins_ok     = 1'b1;
                cmd.op     = iau_pkg::OP_INSERT;
                count_next = count + PosW'(1);
              end
            end
            iau_pkg::REQ_REMOVE: begin
              load_rsp = 1'b1;
              if (position >= count) begin
                rsp_status_next = iau_pkg::ST_RANGE;
              end else begin
                cmd.op     = iau_pkg::OP_REMOVE;
                count_next = count - PosW'(1);
              end
            end
            iau_pkg::REQ_WRITE: begin
              load_rsp = 1'b1;
              if (position >= count) begin
                rsp_status_next = iau_pkg::ST_RANGE;
              end else begin
                cmd.op = iau_pkg::OP_WRITE;
              end
            end
            iau_pkg::REQ_READ: begin
              if (position >= count) begin
                load_rsp        = 1'b1;
                rsp_status_next = iau_pkg::ST_RANGE;
              end else begin
                launch     = 1'b1;
                state_next = iau_pkg::FSM_SCAN;
              end
            end
            iau_pkg::REQ_FIND: begin
              launch     = 1'b1;
              state_next = iau_pkg::FSM_SCAN;
            end
            default: begin
              load_rsp        = 1'b1;
              rsp_status_next = iau_pkg::ST_RANGE;
            end
          endcase
        end
      end
      iau_pkg::FSM_SCAN: begin
        if ((scan_cnt == Full) && rsp_free) begin
          load_rsp   = 1'b1;
          state_next = iau_pkg::FSM_IDLE;
          if (rq_kind == iau_pkg::REQ_READ) begin
            rsp_word_next = p_data[CAPACITY-1];
          end else if (p_hit[CAPACITY-1]) begin
            rsp_found_next = p_idx[CAPACITY-1];
          end else begin
            rsp_status_next = iau_pkg::ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_next = iau_pkg::FSM_IDLE;
      end
    endcase
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iau_pkg::FSM_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Count probe steps.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
    end else if (launch) begin
      scan_cnt <= '0;
    end else if (scan_en) begin
      scan_cnt <= scan_cnt + PosW'(1);
    end
  end

  // Latch the request for the probe.
  always_ff @(posedge clk) begin
    if (launch) begin
      rq_kind <= iau_pkg::req_kind_t'(req_type);
      rq_pos  <= position;
      rq_word <= word_in;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      status         <= rsp_status_next;
      found_position <= rsp_found_next;
      word_out       <= rsp_word_next;
    end
  end

  // Chain of cells, one entry each.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    iau_pkg::word_t  prev_e;
    iau_pkg::word_t  next_e;
    logic            hit_i;
    logic [IdxW-1:0] idx_i;
    iau_pkg::word_t  data_i;

    if (i == 0) begin : g_head
      assign prev_e = entry[i];
      assign hit_i  = 1'b0;
      assign idx_i  = '0;
      assign data_i = '0;
    end else begin : g_body
      assign prev_e = entry[i-1];
      assign hit_i  = p_hit[i-1];
      assign idx_i  = p_idx[i-1];
      assign data_i = p_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = entry[i];
    end else begin : g_mid
      assign next_e = entry[i+1];
    end

    iau_cell #(
      .CAPACITY(CAPACITY),
      .INDEX(i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .pos       (cell_pos),
      .count     (count),
      .scan_en   (scan_en),
      .prev_entry(prev_e),
      .next_entry(next_e),
      .hit_in    (hit_i),
      .idx_in    (idx_i),
      .data_in   (data_i),
      .entry     (entry[i]),
      .hit_out   (p_hit[i]),
      .idx_out   (p_idx[i]),
      .data_out  (p_data[i])
    );
  end

  // Checks.
  `IAU_ASSERT_SAME(a_scan_blocks, clk, rst, state == iau_pkg::FSM_SCAN, req_stall, "request taken during probe")
  `IAU_ASSERT_NEXT(a_insert_grows, clk, rst, ins_ok, count == $past(count) + PosW'(1), "insert did not grow count")
  `IAU_ASSERT_SAME(a_full_status, clk, rst, load_rsp && (rsp_status_next == iau_pkg::ST_FULL), count == Full, "full reported below capacity")

endmodule

`default_nettype wire
